/* design/polyline_tile_tracer_top_macros.svh */
// ----------------------------------------------------------------------------
// Polyline tile tracer assertion macros
// Concurrent assertion wrappers, clocked on clk_i, for the tracer RTL.
// ----------------------------------------------------------------------------
`ifndef POLYLINE_TILE_TRACER_TOP_MACROS_SVH
`define POLYLINE_TILE_TRACER_TOP_MACROS_SVH

// checked outside reset only
`define PTT_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// checked at every edge, reset included
`define PTT_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) (prop)) else $error(msg);

`endif

/* design/ptt_pkg.sv */
// ----------------------------------------------------------------------------
// Polyline tile tracer package
// Field layout, register reset values and sequencer state type.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package ptt_pkg;

  localparam int CoordW      = 6;
  localparam int CountW      = 12;
  localparam int CoordBitsDef = 6;

  localparam int VertexXLsb  = 0;
  localparam int VertexYLsb  = VertexXLsb + CoordW;
  localparam int InDataW     = 16;

  localparam int TileXLsb    = 0;
  localparam int TileYLsb    = TileXLsb + CoordW;
  localparam int TileNumLsb  = TileYLsb + CoordW;
  localparam int OutDataW    = 24;

  localparam logic [CountW-1:0] MaxTilesRst = 12'd512;

  typedef enum logic {
    ST_IDLE,
    ST_STEP
  } state_e;

endpackage

`default_nettype wire

/* design/polyline_tile_tracer_top.sv */
// An anchor, or a vertex before any anchor, is taken in idle and puts no tile out.
// Segment vertex: loaded into the stepper; a joined segment skips its start tile.
// Throughput: one stepper iteration per cycle; a segment covers up to
// max(|dx|,|dy|)+1 tiles, and output stalls hold the stepper.
// Reset (rst_ni low, async): idle, no path open, max_tiles = 512, count zero.
// ----------------------------------------------------------------------------
// Polyline tile tracer
// Bresenham stepper under a two-state sequencer; one tile per cycle, unless the
// output stalls, into a registered output stage, count limited by max_tiles.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "polyline_tile_tracer_top_macros.svh"

module polyline_tile_tracer_top #(
  parameter int CoordBits = ptt_pkg::CoordBitsDef
) (
  input  wire                           clk_i,
  input  wire                           rst_ni,
  input  wire                           s_axis_tvalid,
  output logic                          s_axis_tready,
  // [5:0] vertex_x, [11:6] vertex_y, [15:12] zero
  input  wire  [ptt_pkg::InDataW-1:0]   s_axis_tdata,
  // [0] start_path
  input  wire                           s_axis_tuser,
  output logic                          m_axis_tvalid,
  input  wire                           m_axis_tready,
  // [5:0] tile_x, [11:6] tile_y, [23:12] tile_number
  output logic [ptt_pkg::OutDataW-1:0]  m_axis_tdata,
  output logic                          m_axis_tlast,
  input  wire                           cfg_valid_i,
  output logic                          cfg_ready_o,
  input  wire  [ptt_pkg::CountW-1:0]    cfg_data_i
);

  localparam int CW = ptt_pkg::CoordW;
  localparam int NW = ptt_pkg::CountW;
  localparam int EW = CoordBits + 3;

  ptt_pkg::state_e state_q, state_d;

  logic [NW-1:0]        max_q;
  logic [CoordBits-1:0] prev_x_q, prev_y_q;
  logic                 open_q, joined_q;
  logic [NW-1:0]        count_q;

  logic [CoordBits-1:0] x_q, y_q, tx_q, ty_q, dx_q, dy_q;
  logic                 sx_q, sy_q, skip_q;
  logic signed [EW-1:0] err_q;

  logic                 out_valid_q, out_last_q;
  logic [CW-1:0]        out_x_q, out_y_q;
  logic [NW-1:0]        out_num_q;

  logic [CoordBits-1:0] in_x, in_y, adx, ady;
  logic                 in_acc, seg_load;
  logic signed [EW-1:0] dx_s, dy_s, e2, err_d;
  logic                 at_end, cap, emit, limit_hit, out_free, advance, finish, out_load;

  assign in_x = s_axis_tdata[ptt_pkg::VertexXLsb +: CoordBits];
  assign in_y = s_axis_tdata[ptt_pkg::VertexYLsb +: CoordBits];
  assign adx  = (in_x > prev_x_q) ? in_x - prev_x_q : prev_x_q - in_x;
  assign ady  = (in_y > prev_y_q) ? in_y - prev_y_q : prev_y_q - in_y;

  assign dx_s = signed'(EW'(dx_q));
  assign dy_s = signed'(EW'(dy_q));
  assign e2   = err_q <<< 1;

  always_comb begin
    err_d = err_q;
    if (e2 > -dy_s) err_d = err_d - dy_s;
    if (e2 < dx_s)  err_d = err_d + dx_s;
  end

  assign at_end    = (x_q == tx_q) && (y_q == ty_q);
  assign cap       = (count_q >= max_q);
  assign emit      = !skip_q && !cap;
  assign limit_hit = (({1'b0, count_q} + (NW+1)'(1)) == {1'b0, max_q});
  assign out_free  = !out_valid_q || m_axis_tready;

  // sequencer
  always_comb begin
    state_d       = state_q;
    s_axis_tready = 1'b0;
    in_acc        = 1'b0;
    seg_load      = 1'b0;
    advance       = 1'b0;
    finish        = 1'b0;
    out_load      = 1'b0;
    unique case (state_q)
      ptt_pkg::ST_IDLE: begin
        s_axis_tready = 1'b1;
        in_acc        = s_axis_tvalid;
        if (s_axis_tvalid && !s_axis_tuser && open_q) begin
          seg_load = 1'b1;
          state_d  = ptt_pkg::ST_STEP;
        end
      end
      ptt_pkg::ST_STEP: begin
        if (!emit || out_free) begin
          advance  = 1'b1;
          out_load = emit;
          finish   = at_end || cap || (emit && limit_hit);
          if (finish) state_d = ptt_pkg::ST_IDLE;
        end
      end
      default: state_d = ptt_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ptt_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // path state and config
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_q    <= ptt_pkg::MaxTilesRst;
      prev_x_q <= '0;
      prev_y_q <= '0;
      open_q   <= 1'b0;
      joined_q <= 1'b0;
      count_q  <= '0;
    end else begin
      if (cfg_valid_i) max_q <= cfg_data_i;
      if (in_acc && s_axis_tuser) begin
        prev_x_q <= in_x;
        prev_y_q <= in_y;
        open_q   <= 1'b1;
        joined_q <= 1'b0;
        count_q  <= '0;
      end else if (seg_load) begin
        prev_x_q <= in_x;
        prev_y_q <= in_y;
        joined_q <= 1'b1;
      end else if (out_load) begin
        count_q  <= count_q + NW'(1);
      end
    end
  end

  // stepper
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      skip_q <= 1'b0;
    end else if (seg_load) begin
      skip_q <= joined_q;
    end else if (advance) begin
      skip_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (seg_load) begin
      x_q   <= prev_x_q;
      y_q   <= prev_y_q;
      tx_q  <= in_x;
      ty_q  <= in_y;
      dx_q  <= adx;
      dy_q  <= ady;
      sx_q  <= (in_x < prev_x_q);
      sy_q  <= (in_y < prev_y_q);
      err_q <= signed'(EW'(adx)) - signed'(EW'(ady));
    end else if (advance && !at_end) begin
      err_q <= err_d;
      if (e2 > -dy_s) x_q <= sx_q ? x_q - CoordBits'(1) : x_q + CoordBits'(1);
      if (e2 < dx_s)  y_q <= sy_q ? y_q - CoordBits'(1) : y_q + CoordBits'(1);
    end
  end

  // output stage
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_x_q    <= CW'(x_q);
      out_y_q    <= CW'(y_q);
      out_num_q  <= count_q;
      out_last_q <= at_end || limit_hit;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {out_num_q, out_y_q, out_x_q};
  assign m_axis_tlast  = out_last_q;
  assign cfg_ready_o   = 1'b1;

  `PTT_ASSERT(a_emit_under_limit, out_load |-> (count_q < max_q), "tile emitted past max_tiles")
  `PTT_ASSERT(a_number_tracks_count, out_load |=> (out_num_q == $past(count_q)), "tile number mismatch")
  `PTT_ASSERT(a_end_returns_idle, (state_q == ptt_pkg::ST_STEP && advance && at_end) |=> (state_q == ptt_pkg::ST_IDLE), "stepper ran past segment end")
  `PTT_ASSERT(a_no_load_when_full, (out_valid_q && !m_axis_tready) |-> !out_load, "output overwritten while stalled")
  `PTT_ASSERT_ALWAYS(a_reset_quiet, !rst_ni |=> (!out_valid_q && state_q == ptt_pkg::ST_IDLE), "not quiet in reset")

endmodule

`default_nettype wire

/* bench/tb_polyline_tile_tracer_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Polyline tile tracer testbench
// Feeds anchors and path vertices, then checks every traced tile against a
// Bresenham trace kept in a scoreboard. max_tiles changes between phases.
// ----------------------------------------------------------------------------

class tile_scoreboard;

  typedef struct packed {
    bit [ptt_pkg::CoordW-1:0] tile_x;
    bit [ptt_pkg::CoordW-1:0] tile_y;
    bit [ptt_pkg::CountW-1:0] tile_number;
    bit                       last_flag;
  } tile_t;

  int unsigned max_tiles = ptt_pkg::MaxTilesRst;
  int          prev_x;
  int          prev_y;
  bit          path_open;
  bit          joined_segment;
  int unsigned tile_count;
  tile_t       tiles_q[$];
  int          errors;

  // one accepted vertex: queue the tiles of its segment
  function void trace_vertex(bit [5:0] vx, bit [5:0] vy, bit anchor);
    int    x, y, dx, dy, sx, sy, err, e2, k;
    bit    skip;
    tile_t t;
    if (anchor) begin
      prev_x = vx;
      prev_y = vy;
      path_open = 1'b1;
      joined_segment = 1'b0;
      tile_count = 0;
      return;
    end
    if (!path_open) return;
    x = prev_x;
    y = prev_y;
    dx = (vx > x) ? vx - x : x - vx;
    dy = (vy > y) ? vy - y : y - vy;
    sx = (x < vx) ? 1 : -1;
    sy = (y < vy) ? 1 : -1;
    err = dx - dy;
    skip = joined_segment;
    k = 0;
    forever begin
      if (!skip && tile_count < max_tiles) begin
        t.tile_x = 6'(x);
        t.tile_y = 6'(y);
        t.tile_number = 12'(tile_count);
        t.last_flag = 1'b0;
        tiles_q.push_back(t);
        tile_count++;
        k++;
      end
      skip = 1'b0;
      if (x == vx && y == vy) break;
      e2 = 2 * err;
      if (e2 > -dy) begin
        err -= dy;
        x += sx;
      end
      if (e2 < dx) begin
        err += dx;
        y += sy;
      end
    end
    if (k > 0) tiles_q[tiles_q.size()-1].last_flag = 1'b1;
    prev_x = vx;
    prev_y = vy;
    joined_segment = 1'b1;
  endfunction

  function void check_tile(bit [ptt_pkg::OutDataW-1:0] data, bit last_bit);
    tile_t e;
    tile_t a;
    if (tiles_q.size() == 0) begin
      $error("unexpected tile: tdata=%h tlast=%0b", data, last_bit);
      errors++;
      return;
    end
    e = tiles_q.pop_front();
    a.tile_x = data[ptt_pkg::TileXLsb +: ptt_pkg::CoordW];
    a.tile_y = data[ptt_pkg::TileYLsb +: ptt_pkg::CoordW];
    a.tile_number = data[ptt_pkg::TileNumLsb +: ptt_pkg::CountW];
    a.last_flag = last_bit;
    if (a.tile_x != e.tile_x) begin
      $error("tile_x: expected %0d, got %0d", e.tile_x, a.tile_x);
      errors++;
    end
    if (a.tile_y != e.tile_y) begin
      $error("tile_y: expected %0d, got %0d", e.tile_y, a.tile_y);
      errors++;
    end
    if (a.tile_number != e.tile_number) begin
      $error("tile_number: expected %0d, got %0d", e.tile_number, a.tile_number);
      errors++;
    end
    if (a.last_flag != e.last_flag) begin
      $error("last: expected %0b, got %0b", e.last_flag, a.last_flag);
      errors++;
    end
  endfunction

endclass

module tb_polyline_tile_tracer_top;

  localparam int QuietLimit  = 3000;
  localparam int SettleCycles = 80;

  logic                          clk_i = 1'b0;
  logic                          rst_ni = 1'b0;
  logic                          s_axis_tvalid = 1'b0;
  logic                          s_axis_tready;
  logic [ptt_pkg::InDataW-1:0]   s_axis_tdata = '0;
  logic                          s_axis_tuser = 1'b0;
  logic                          m_axis_tvalid;
  logic                          m_axis_tready = 1'b0;
  logic [ptt_pkg::OutDataW-1:0]  m_axis_tdata;
  logic                          m_axis_tlast;
  logic                          cfg_valid_i = 1'b0;
  logic                          cfg_ready_o;
  logic [ptt_pkg::CountW-1:0]    cfg_data_i = '0;

  tile_scoreboard sb;
  int             quiet_cycles = 0;
  int             burst_left = 0;
  int             rx_left = 0;
  int             rx_mode = 0;
  int             last_x = 0;
  int             last_y = 0;

  polyline_tile_tracer_top u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_data_i    (cfg_data_i)
  );

  always #5 clk_i = ~clk_i;

  // receiver: ready, random, sparse or periodic stretches
  always @(negedge clk_i) begin
    if (rx_left == 0) begin
      rx_mode = $urandom_range(0, 3);
      rx_left = $urandom_range(4, 60);
    end
    rx_left--;
    case (rx_mode)
      0: m_axis_tready = 1'b1;
      1: m_axis_tready = 1'($urandom_range(0, 1));
      2: m_axis_tready = ($urandom_range(0, 3) == 0);
      default: m_axis_tready = rx_left[2];
    endcase
  end

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) sb.check_tile(m_axis_tdata, m_axis_tlast);
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (cfg_valid_i && cfg_ready_o)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= QuietLimit) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  task automatic send_vertex(input int x, input int y, input bit anchor);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
      burst_left = $urandom_range(1, 20);
      if (gap > 0) begin
        @(negedge clk_i);
        s_axis_tvalid = 1'b0;
        repeat (gap - 1) @(negedge clk_i);
      end
    end
    @(negedge clk_i);
    s_axis_tvalid = 1'b1;
    s_axis_tdata = {4'b0, 6'(y), 6'(x)};
    s_axis_tuser = anchor;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    sb.trace_vertex(6'(x), 6'(y), anchor);
    burst_left--;
    last_x = x;
    last_y = y;
  endtask

  // drain all tiles, then give a dropped-tile segment time to finish
  task automatic settle();
    @(negedge clk_i);
    s_axis_tvalid = 1'b0;
    burst_left = 0;
    while (sb.tiles_q.size() > 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic write_max_tiles(input int value);
    @(negedge clk_i);
    cfg_valid_i = 1'b1;
    cfg_data_i = 12'(value);
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    sb.max_tiles = value;
    @(negedge clk_i);
    cfg_valid_i = 1'b0;
  endtask

  function automatic int near_coord(int c);
    int v;
    v = c + $urandom_range(0, 14) - 7;
    if (v < 0) v = 0;
    if (v > 63) v = 63;
    return v;
  endfunction

  function automatic int edge_coord();
    return $urandom_range(0, 1) ? $urandom_range(56, 63) : $urandom_range(0, 7);
  endfunction

  // far: corner-to-corner segments, long paths
  task automatic run_path(input int n_items, input int anchor_pct, input bit far);
    int  x, y, pick;
    bit  anchor;
    for (int i = 0; i < n_items; i++) begin
      anchor = (i == 0) || ($urandom_range(0, 99) < anchor_pct);
      pick = $urandom_range(0, 9);
      if (far) begin
        x = edge_coord();
        y = edge_coord();
      end else if (pick < 4) begin
        x = $urandom_range(0, 63);
        y = $urandom_range(0, 63);
      end else if (pick < 7) begin
        x = near_coord(last_x);
        y = near_coord(last_y);
      end else if (pick < 8) begin
        x = last_x;
        y = last_y;
      end else begin
        x = $urandom_range(0, 1) ? 63 : 0;
        y = $urandom_range(0, 1) ? 63 : 0;
      end
      send_vertex(x, y, anchor);
    end
  endtask

  initial begin
    sb = new();
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // reset limit: vertex before any anchor, full diagonal, repeat, axes
    send_vertex(10, 20, 1'b0);
    send_vertex(0, 0, 1'b1);
    send_vertex(63, 63, 1'b0);
    send_vertex(63, 63, 1'b0);
    send_vertex(0, 63, 1'b0);
    send_vertex(0, 0, 1'b0);
    send_vertex(5, 2, 1'b0);
    send_vertex(3, 40, 1'b0);
    send_vertex(63, 0, 1'b1);
    send_vertex(63, 0, 1'b0);
    send_vertex(0, 63, 1'b0);
    settle();

    // limit of one: second segment is dropped entirely
    write_max_tiles(1);
    send_vertex(20, 20, 1'b1);
    send_vertex(25, 30, 1'b0);
    send_vertex(40, 10, 1'b0);
    settle();

    // limit hit mid-segment
    write_max_tiles(10);
    send_vertex(0, 0, 1'b1);
    send_vertex(30, 5, 1'b0);
    send_vertex(31, 5, 1'b0);
    settle();

    // one long path toward the top of the count range
    write_max_tiles(4095);
    run_path(80, 0, 1'b1);
    settle();

    write_max_tiles($urandom_range(1, 4095));
    run_path(38, 10, 1'b0);
    settle();
    write_max_tiles($urandom_range(1, 40));
    run_path(38, 10, 1'b0);
    settle();
    write_max_tiles(4095);
    run_path(38, 10, 1'b0);
    settle();
    write_max_tiles($urandom_range(41, 600));
    run_path(38, 10, 1'b0);
    settle();

    if (sb.errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

/* polyline_tile_tracer_top.f */
+incdir+design
design/ptt_pkg.sv
design/polyline_tile_tracer_top.sv
bench/tb_polyline_tile_tracer_top.sv
